// ----- design/twdw_pkg.sv -----
// ----------------------------------------------------------------------------
// twdw_pkg
// Shared types and constants for the two-wire display digit writer.
// ----------------------------------------------------------------------------
package twdw_pkg;

  localparam int CfgIndexWidth = 8;
  localparam int InDataWidth   = 16;
  localparam int OutDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] REG_DATA_CMD    = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ADDR_BASE   = 8'd1;
  localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_CTL = 8'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ACK_TIMEOUT = 8'd3;

  localparam logic [7:0] DataCmdReset    = 8'd64;
  localparam logic [7:0] AddrBaseReset   = 8'd192;
  localparam logic [7:0] DisplayCtlReset = 8'd136;
  localparam logic [7:0] AckTimeoutReset = 8'd100;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SLOT_DATA_CMD = 2'd0;
  localparam logic [1:0] SLOT_ADDR_CMD = 2'd1;
  localparam logic [1:0] SLOT_SEGMENTS = 2'd2;
  localparam logic [1:0] SLOT_DISPLAY  = 2'd3;

  typedef enum logic [13:0] {
    PH_IDLE     = 14'b00000000000001,
    PH_START1   = 14'b00000000000010,
    PH_START2   = 14'b00000000000100,
    PH_BIT_LOW  = 14'b00000000001000,
    PH_BIT_SET  = 14'b00000000010000,
    PH_BIT_HIGH = 14'b00000000100000,
    PH_ACK_REL  = 14'b00000001000000,
    PH_ACK_WAIT = 14'b00000010000000,
    PH_STOP1    = 14'b00000100000000,
    PH_STOP2    = 14'b00001000000000,
    PH_STOP3    = 14'b00010000000000,
    PH_GAP      = 14'b00100000000000,
    PH_ABORT2   = 14'b01000000000000,
    PH_ABORT3   = 14'b10000000000000
  } phase_t;

endpackage

// ----- design/two_wire_display_digit_writer.sv -----
// ----------------------------------------------------------------------------
// two_wire_display_digit_writer
// Sequencer for a two-wire LED display driver: one digit write per request,
// advanced one pin step per tick word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 contents
//  s_axis    in         s_axis_tvalid/tready      tick or write request
//  m_axis    out        m_axis_tvalid/tready      pin levels and status flags
//  cfg       in         cfg_valid/cfg_ready       register index and data
//
//  Each input word is handled by a single sequencer transition; a new word
//  can be taken every cycle while the output is not stalled.
//  The result register frees itself when taken, so input and output can both
//  move in the same cycle; a stalled output holds the input off.
//  Reset is synchronous; all but m_axis_tdata return to documented defaults.
// ----------------------------------------------------------------------------
module two_wire_display_digit_writer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // digit_address[2:0], segments[10:3], data_line_in[11], zero fill
  input  logic [twdw_pkg::InDataWidth-1:0]     s_axis_tdata,
  // command[0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // clock_line[0], data_line_out[1], data_drive[2], busy_res[3],
  // write_rejected[4], ack_error[5], done_res[6], zero fill
  output logic [twdw_pkg::OutDataWidth-1:0]    m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [twdw_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [7:0]                           cfg_data
);
  import twdw_pkg::*;

  logic [7:0] data_cmd, addr_base, display_ctl, ack_timeout;

  phase_t     phase, phase_next;
  logic [1:0] byte_slot, byte_slot_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] wait_count, wait_count_next;
  logic [2:0] held_address, held_address_next;
  logic [7:0] held_segments, held_segments_next;
  logic       clock_level, clock_level_next;
  logic       data_level, data_level_next;
  logic       drive_enable, drive_enable_next;
  logic       rejected, err, done;

  logic       in_accept;
  logic [2:0] in_address;
  logic [7:0] in_segments;
  logic       line_in;
  logic [7:0] slot_byte;
  logic [7:0] wait_inc;

  assign in_address  = s_axis_tdata[2:0];
  assign in_segments = s_axis_tdata[10:3];
  assign line_in     = s_axis_tdata[11];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign wait_inc      = wait_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_cmd    <= DataCmdReset;
      addr_base   <= AddrBaseReset;
      display_ctl <= DisplayCtlReset;
      ack_timeout <= AckTimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DATA_CMD:    data_cmd    <= cfg_data;
        REG_ADDR_BASE:   addr_base   <= cfg_data;
        REG_DISPLAY_CTL: display_ctl <= cfg_data;
        REG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (byte_slot)
      SLOT_DATA_CMD: slot_byte = data_cmd;
      SLOT_ADDR_CMD: slot_byte = addr_base | {5'd0, held_address};
      SLOT_SEGMENTS: slot_byte = held_segments;
      default:       slot_byte = display_ctl;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_slot_next     = byte_slot;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    wait_count_next    = wait_count;
    held_address_next  = held_address;
    held_segments_next = held_segments;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    drive_enable_next  = drive_enable;
    rejected           = 1'b0;
    err                = 1'b0;
    done               = 1'b0;

    if (s_axis_tuser == CMD_WRITE) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        held_address_next  = in_address;
        held_segments_next = in_segments;
        byte_slot_next     = SLOT_DATA_CMD;
        phase_next         = PH_START1;
      end
    end else begin
      case (phase)
        PH_START1: begin
          drive_enable_next = 1'b1;
          clock_level_next  = 1'b1;
          data_level_next   = 1'b1;
          phase_next        = PH_START2;
        end
        PH_START2: begin
          data_level_next = 1'b0;
          shift_byte_next = slot_byte;
          bit_index_next  = 3'd0;
          phase_next      = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          clock_level_next  = 1'b0;
          drive_enable_next = 1'b1;
          phase_next        = PH_BIT_SET;
        end
        PH_BIT_SET: begin
          data_level_next = shift_byte[0];
          phase_next      = PH_BIT_HIGH;
        end
        PH_BIT_HIGH: begin
          clock_level_next = 1'b1;
          shift_byte_next  = {1'b0, shift_byte[7:1]};
          if (bit_index == 3'd7) begin
            bit_index_next = 3'd0;
            phase_next     = PH_ACK_REL;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_BIT_LOW;
          end
        end
        PH_ACK_REL: begin
          clock_level_next  = 1'b0;
          drive_enable_next = 1'b0;
          wait_count_next   = 8'd0;
          phase_next        = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!line_in) begin
            clock_level_next = 1'b1;
            if (byte_slot == SLOT_ADDR_CMD) begin
              byte_slot_next  = SLOT_SEGMENTS;
              shift_byte_next = held_segments;
              bit_index_next  = 3'd0;
              phase_next      = PH_BIT_LOW;
            end else begin
              phase_next = PH_STOP1;
            end
          end else begin
            wait_count_next = wait_inc;
            if (wait_inc >= ack_timeout) begin
              clock_level_next  = 1'b0;
              data_level_next   = 1'b0;
              drive_enable_next = 1'b1;
              err               = 1'b1;
              phase_next        = PH_ABORT2;
            end
          end
        end
        PH_STOP1: begin
          clock_level_next  = 1'b0;
          data_level_next   = 1'b0;
          drive_enable_next = 1'b1;
          phase_next        = PH_STOP2;
        end
        PH_STOP2: begin
          clock_level_next = 1'b1;
          phase_next       = PH_STOP3;
        end
        PH_STOP3: begin
          data_level_next = 1'b1;
          if (byte_slot == SLOT_DATA_CMD) begin
            phase_next = PH_GAP;
          end else if (byte_slot == SLOT_SEGMENTS) begin
            byte_slot_next = SLOT_DISPLAY;
            phase_next     = PH_START1;
          end else begin
            done           = 1'b1;
            byte_slot_next = SLOT_DATA_CMD;
            phase_next     = PH_IDLE;
          end
        end
        PH_GAP: begin
          byte_slot_next = SLOT_ADDR_CMD;
          phase_next     = PH_START1;
        end
        PH_ABORT2: begin
          clock_level_next = 1'b1;
          phase_next       = PH_ABORT3;
        end
        PH_ABORT3: begin
          data_level_next = 1'b1;
          byte_slot_next  = SLOT_DATA_CMD;
          phase_next      = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_slot     <= SLOT_DATA_CMD;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      wait_count    <= 8'd0;
      held_address  <= 3'd0;
      held_segments <= 8'd0;
      clock_level   <= 1'b1;
      data_level    <= 1'b1;
      drive_enable  <= 1'b1;
    end else if (in_accept) begin
      phase         <= phase_next;
      byte_slot     <= byte_slot_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      wait_count    <= wait_count_next;
      held_address  <= held_address_next;
      held_segments <= held_segments_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      drive_enable  <= drive_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tdata <= {1'b0, done, err, rejected, (phase_next != PH_IDLE),
                       drive_enable_next, drive_enable_next & data_level_next,
                       clock_level_next};
    end
  end

  a_released_reads_low: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("data line reported high while released");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[3] && !m_axis_tdata[5])
    else $error("completion flagged while busy or with ack error");

  a_reject_holds_phase: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_axis_tuser == CMD_WRITE && phase != PH_IDLE |=> phase == $past(phase))
    else $error("rejected write moved the sequencer");

  a_error_enters_abort: assert property (@(posedge clk) disable iff (rst)
    in_accept && err |=> phase == PH_ABORT2 && !clock_level && drive_enable)
    else $error("ack timeout did not begin the stop");

endmodule
